FILE: rtl/npsc_pkg.sv
`timescale 1ns / 1ps

package npsc_pkg;

  // Coordinate format: signed fixed point with FRAC_BITS fraction bits.
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // The near-plane register is 31 bits unsigned in the same fixed-point format.
  localparam int NEAR_WIDTH = 31;

  // Default near plane is 0.1, rounded to the nearest step.
  localparam logic [NEAR_WIDTH-1:0] NEAR_RESET = NEAR_WIDTH'(((1 << FRAC_BITS) + 5) / 10);

  // Working width holds any coordinate, the near plane and their differences.
  localparam int WORK_WIDTH = ((COORD_WIDTH > NEAR_WIDTH) ? COORD_WIDTH : NEAR_WIDTH + 1) + 1;

  // Magnitudes of the differences fit in one bit less.
  localparam int MAG_WIDTH = WORK_WIDTH - 1;

  // Stream widths: four coordinates padded to whole bytes, three status bits.
  localparam int DATA_WIDTH = ((4 * COORD_WIDTH + 7) / 8) * 8;
  localparam int USER_WIDTH = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [WORK_WIDTH-1:0]  work_t;
  typedef logic        [MAG_WIDTH-1:0]   mag_t;
  typedef logic        [2*MAG_WIDTH-1:0] prod_t;

  typedef enum logic [1:0] {
    CLIP_NONE   = 2'd0,
    CLIP_FIRST  = 2'd1,
    CLIP_SECOND = 2'd2
  } clip_t;

  // One result item.
  typedef struct packed {
    logic   visible;
    clip_t  clipped_end;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } result_t;

  // Side information that travels down the pipeline next to the arithmetic.
  typedef struct packed {
    logic    neg;
    coord_t  xb;
    result_t res;
  } meta_t;

endpackage

FILE: rtl/near_plane_segment_clip.sv
`timescale 1ns / 1ps

// Near-plane clipper for 2D view-space segments (depth along y, signed Q16.16).
// A segment is accepted every cycle while the output side keeps up; results
// leave in input order, after passing through a difference stage, a
// magnitude stage, a 32x32 multiply stage, one pipeline stage per quotient
// bit of the restoring divider, and the output register. An output register
// plus a one-entry skid buffer decouple the two sides, so a new segment is
// still taken while one result waits to be collected. The near-plane
// register may be written at any time the block is idle.
module near_plane_segment_clip (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input segment.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0 up: first_x, first_y, second_x, second_y.
  input  logic [npsc_pkg::DATA_WIDTH-1:0]     in_tdata,
  // Clipped segment.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: out_first_x, out_first_y, out_second_x, out_second_y.
  output logic [npsc_pkg::DATA_WIDTH-1:0]     out_tdata,
  // Fields from bit 0 up: visible, clipped_end.
  output logic [npsc_pkg::USER_WIDTH-1:0]     out_tuser,
  // Near-plane register write.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [npsc_pkg::NEAR_WIDTH-1:0]     cfg_data
);

  localparam int CW = npsc_pkg::COORD_WIDTH;

  // Near-plane register.
  logic [npsc_pkg::NEAR_WIDTH-1:0] near_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= npsc_pkg::NEAR_RESET;
    end else if (cfg_valid) begin
      near_r <= cfg_data;
    end
  end

  // The whole pipeline moves unless the skid buffer is holding a result.
  logic en;
  logic skid_v_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  // Difference stage: classify the endpoints and form the three differences.
  npsc_pkg::coord_t ix1, iy1, ix2, iy2, near_coord;
  npsc_pkg::work_t  x1e, y1e, x2e, y2e, nre, xbe, ybe, xoe, yoe;
  logic             behind1, behind2;
  npsc_pkg::meta_t  a_meta_nxt;

  assign ix1 = in_tdata[CW-1:0];
  assign iy1 = in_tdata[2*CW-1:CW];
  assign ix2 = in_tdata[3*CW-1:2*CW];
  assign iy2 = in_tdata[4*CW-1:3*CW];

  assign nre        = npsc_pkg::work_t'(near_r);
  assign near_coord = nre[CW-1:0];

  always_comb begin
    x1e = npsc_pkg::work_t'(ix1);
    y1e = npsc_pkg::work_t'(iy1);
    x2e = npsc_pkg::work_t'(ix2);
    y2e = npsc_pkg::work_t'(iy2);
    behind1 = y1e <= nre;
    behind2 = y2e <= nre;

    // The first endpoint is the one moved unless it lies in front.
    if (behind1) begin
      xbe = x1e;
      ybe = y1e;
      xoe = x2e;
      yoe = y2e;
    end else begin
      xbe = x2e;
      ybe = y2e;
      xoe = x1e;
      yoe = y1e;
    end

    a_meta_nxt.neg             = 1'b0;
    a_meta_nxt.xb              = behind1 ? ix1 : ix2;
    a_meta_nxt.res.visible     = !(behind1 && behind2);
    a_meta_nxt.res.x1          = ix1;
    a_meta_nxt.res.y1          = iy1;
    a_meta_nxt.res.x2          = ix2;
    a_meta_nxt.res.y2          = iy2;
    a_meta_nxt.res.clipped_end = npsc_pkg::CLIP_NONE;
    if (behind1 && !behind2) begin
      a_meta_nxt.res.clipped_end = npsc_pkg::CLIP_FIRST;
      a_meta_nxt.res.y1          = near_coord;
    end else if (behind2 && !behind1) begin
      a_meta_nxt.res.clipped_end = npsc_pkg::CLIP_SECOND;
      a_meta_nxt.res.y2          = near_coord;
    end
  end

  logic             a_v_r;
  npsc_pkg::work_t  a_num_r;
  npsc_pkg::work_t  a_dx_r;
  npsc_pkg::work_t  a_den_r;
  npsc_pkg::meta_t  a_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
    end
    if (en) begin
      a_num_r  <= nre - ybe;
      a_dx_r   <= xoe - xbe;
      a_den_r  <= yoe - ybe;
      a_meta_r <= a_meta_nxt;
    end
  end

  // Magnitude stage: strip the sign of the lateral difference.
  logic             b_v_r;
  npsc_pkg::mag_t   b_a_r, b_b_r, b_d_r;
  npsc_pkg::meta_t  b_meta_r;
  npsc_pkg::meta_t  b_meta_nxt;
  npsc_pkg::work_t  dx_neg;

  assign dx_neg = -a_dx_r;

  always_comb begin
    b_meta_nxt     = a_meta_r;
    b_meta_nxt.neg = a_dx_r[npsc_pkg::WORK_WIDTH-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
    if (en) begin
      b_a_r    <= npsc_pkg::mag_t'(a_num_r);
      b_b_r    <= b_meta_nxt.neg ? npsc_pkg::mag_t'(dx_neg) : npsc_pkg::mag_t'(a_dx_r);
      b_d_r    <= npsc_pkg::mag_t'(a_den_r);
      b_meta_r <= b_meta_nxt;
    end
  end

  // Multiply and divide.
  logic             pipe_v;
  npsc_pkg::mag_t   pipe_q;
  npsc_pkg::meta_t  pipe_meta;

  npsc_mul_div u_mul_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_v_r),
    .in_a      (b_a_r),
    .in_b      (b_b_r),
    .in_d      (b_d_r),
    .in_meta   (b_meta_r),
    .out_valid (pipe_v),
    .out_q     (pipe_q),
    .out_meta  (pipe_meta)
  );

  // Apply the quotient to the moved endpoint's x.
  npsc_pkg::work_t  qe, xb_ext, x_new;
  npsc_pkg::result_t pipe_res;

  always_comb begin
    qe       = npsc_pkg::work_t'(pipe_q);
    xb_ext   = npsc_pkg::work_t'(pipe_meta.xb);
    x_new    = pipe_meta.neg ? (xb_ext - qe) : (xb_ext + qe);
    pipe_res = pipe_meta.res;
    case (pipe_meta.res.clipped_end)
      npsc_pkg::CLIP_FIRST:  pipe_res.x1 = x_new[CW-1:0];
      npsc_pkg::CLIP_SECOND: pipe_res.x2 = x_new[CW-1:0];
      default:               pipe_res = pipe_meta.res;
    endcase
  end

  // Output register with a one-entry skid buffer behind it.
  logic              push, pop;
  logic              out_v_r, out_v_nxt, skid_v_nxt;
  npsc_pkg::result_t out_r, skid_r;

  assign push = pipe_v && en;
  assign pop  = out_v_r && out_tready;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || pop) begin
      out_v_nxt  = skid_v_r || push;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    if (!out_v_r || pop) begin
      out_r <= skid_v_r ? skid_r : pipe_res;
    end else if (push) begin
      skid_r <= pipe_res;
    end
  end

  // Pack the result onto the stream.
  assign out_tvalid = out_v_r;
  assign out_tuser  = {out_r.clipped_end, out_r.visible};

  always_comb begin
    out_tdata           = '0;
    out_tdata[4*CW-1:0] = {out_r.y2, out_r.x2, out_r.y1, out_r.x1};
  end

  // A segment reported invisible never names a clipped endpoint.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.visible || out_r.clipped_end == npsc_pkg::CLIP_NONE))
    else $error("invisible segment reports a clipped endpoint");

  // A result arriving while the output is held must land in the skid buffer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_v_r && !out_tready) |=> skid_v_r)
    else $error("result lost while output stalled");

  // A clipped first endpoint sits on the near plane.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.clipped_end == npsc_pkg::CLIP_FIRST) |-> (out_r.y1 == near_coord))
    else $error("clipped first endpoint is off the near plane");

  // A clipped second endpoint sits on the near plane.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.clipped_end == npsc_pkg::CLIP_SECOND) |-> (out_r.y2 == near_coord))
    else $error("clipped second endpoint is off the near plane");

endmodule

FILE: rtl/npsc_mul_div.sv
`timescale 1ns / 1ps

// Pipelined floor(a * b / d) for a < d, so the quotient fits in MAG_WIDTH bits.
// One multiply stage, then one restoring division step per stage.
module npsc_mul_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  npsc_pkg::mag_t   in_a,
  input  npsc_pkg::mag_t   in_b,
  input  npsc_pkg::mag_t   in_d,
  input  npsc_pkg::meta_t  in_meta,
  output logic             out_valid,
  output npsc_pkg::mag_t   out_q,
  output npsc_pkg::meta_t  out_meta
);

  localparam int MW    = npsc_pkg::MAG_WIDTH;
  localparam int STEPS = npsc_pkg::MAG_WIDTH;

  // Multiply stage registers.
  logic             m_v_r;
  npsc_pkg::prod_t  m_prod_r;
  npsc_pkg::prod_t  m_prod_nxt;
  npsc_pkg::mag_t   m_d_r;
  npsc_pkg::meta_t  m_meta_r;

  // Division stage registers.
  logic             v_r      [STEPS];
  npsc_pkg::mag_t   rem_r    [STEPS];
  npsc_pkg::mag_t   low_r    [STEPS];
  npsc_pkg::mag_t   d_r      [STEPS];
  npsc_pkg::meta_t  meta_r   [STEPS];
  npsc_pkg::mag_t   rem_nxt  [STEPS];
  npsc_pkg::mag_t   low_nxt  [STEPS];

  // Inputs of each division stage.
  logic             src_v    [STEPS];
  npsc_pkg::mag_t   src_rem  [STEPS];
  npsc_pkg::mag_t   src_low  [STEPS];
  npsc_pkg::mag_t   src_d    [STEPS];
  npsc_pkg::meta_t  src_meta [STEPS];
  logic [MW:0]      trial    [STEPS];
  logic [MW:0]      diff     [STEPS];
  logic             ge       [STEPS];

  // The full product; the upper half is the first partial remainder.
  assign m_prod_nxt = npsc_pkg::prod_t'(in_a) * npsc_pkg::prod_t'(in_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= in_valid;
    end
    if (en) begin
      m_prod_r <= m_prod_nxt;
      m_d_r    <= in_d;
      m_meta_r <= in_meta;
    end
  end

  // Route each stage's inputs from the stage before it.
  always_comb begin
    src_v[0]    = m_v_r;
    src_rem[0]  = m_prod_r[2*MW-1:MW];
    src_low[0]  = m_prod_r[MW-1:0];
    src_d[0]    = m_d_r;
    src_meta[0] = m_meta_r;
    for (int k = 1; k < STEPS; k++) begin
      src_v[k]    = v_r[k-1];
      src_rem[k]  = rem_r[k-1];
      src_low[k]  = low_r[k-1];
      src_d[k]    = d_r[k-1];
      src_meta[k] = meta_r[k-1];
    end
  end

  // One restoring step per stage; quotient bits shift in at the bottom of low.
  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      trial[k]   = {src_rem[k], src_low[k][MW-1]};
      diff[k]    = trial[k] - {1'b0, src_d[k]};
      ge[k]      = trial[k] >= {1'b0, src_d[k]};
      rem_nxt[k] = ge[k] ? diff[k][MW-1:0] : trial[k][MW-1:0];
      low_nxt[k] = {src_low[k][MW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STEPS; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        v_r[k] <= src_v[k];
      end
    end
    if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        rem_r[k]  <= rem_nxt[k];
        low_r[k]  <= low_nxt[k];
        d_r[k]    <= src_d[k];
        meta_r[k] <= src_meta[k];
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_q     = low_r[STEPS-1];
  assign out_meta  = meta_r[STEPS-1];

endmodule
